FILE: hdl/url_percent_decoder_top_defines.svh
// assertion macros used by the decoder top level
`ifndef URL_PERCENT_DECODER_TOP_DEFINES_SVH
`define URL_PERCENT_DECODER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define UPD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("upd assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define UPD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("upd assertion failed");

`endif

FILE: hdl/upd_pkg.sv
package upd_pkg;

	localparam logic [7:0] CHAR_PCT   = 8'h25;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_PCT  = 2'd1;
	localparam logic [1:0] PH_HIGH = 2'd2;

	// all results caused by one input transfer
	typedef struct packed {
		logic [1:0]      cnt;
		logic            pad;
		logic [2:0][7:0] bytes;
		logic            last;
		logic [1:0]      left;
	} bundle_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] nibble(input logic [7:0] c);
		logic [4:0] v;
		v = c[6] ? (5'({2'b00, c[2:0]}) + 5'd9) : {1'b0, c[3:0]};
		return v[3:0];
	endfunction

	function automatic logic [7:0] map_plus(input logic [7:0] c);
		return (c == CHAR_PLUS) ? CHAR_SPACE : c;
	endfunction

endpackage

FILE: hdl/upd_front.sv
module upd_front import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       last_byte,
	input  logic       q_full,
	output logic       push,
	output bundle_t    push_data
);

	logic [1:0] phase_q;
	logic [7:0] held_q;
	logic [1:0] ph_nxt;
	logic [7:0] held_nxt;
	logic       xfer;

	assign in_ready = !q_full;
	assign xfer     = in_valid && in_ready;

	// classify the byte against the escape state and collect its results
	always_comb begin
		logic [1:0] n;
		logic [2:0][7:0] b;
		logic [1:0] ph;
		logic [7:0] hl;
		logic pad;
		logic [1:0] left;
		n    = 2'd0;
		b    = '0;
		ph   = phase_q;
		hl   = held_q;
		pad  = 1'b0;
		left = 2'd0;
		if (!phase_q[1]) begin
			if (phase_q == PH_IDLE) begin
				if (in_byte == CHAR_PCT) begin
					ph = PH_PCT;
				end else begin
					b[0] = map_plus(in_byte);
					n    = 2'd1;
				end
			end else begin
				hl = in_byte;
				ph = PH_HIGH;
			end
		end else begin
			ph = PH_IDLE;
			if (is_hex(held_q) && is_hex(in_byte)) begin
				b[0] = {nibble(held_q), nibble(in_byte)};
				n    = 2'd1;
			end else begin
				// failed escape: literal percent, then replay held and current
				b[0] = CHAR_PCT;
				n    = 2'd1;
				if (held_q == CHAR_PCT) begin
					ph = PH_PCT;
				end else begin
					b[1] = map_plus(held_q);
					n    = 2'd2;
				end
				if (ph == PH_IDLE) begin
					if (in_byte == CHAR_PCT) begin
						ph = PH_PCT;
					end else begin
						b[n] = map_plus(in_byte);
						n    = n + 2'd1;
					end
				end else begin
					hl = in_byte;
					ph = PH_HIGH;
				end
			end
		end
		// buffer end drops any pending escape
		if (last_byte) begin
			left = ph;
			if (n == 2'd0) begin
				n   = 2'd1;
				pad = 1'b1;
			end
			ph = PH_IDLE;
		end
		ph_nxt          = ph;
		held_nxt        = hl;
		push_data.cnt   = n;
		push_data.pad   = pad;
		push_data.bytes = b;
		push_data.last  = last_byte;
		push_data.left  = left;
	end

	assign push = xfer && (push_data.cnt != 2'd0);

	// escape state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= 8'h00;
		end else if (xfer) begin
			phase_q <= ph_nxt;
			held_q  <= held_nxt;
		end
	end

endmodule

FILE: hdl/upd_queue.sv
module upd_queue import upd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	input  logic    pop,
	output logic    full,
	output logic    head_valid,
	output bundle_t head
);

	bundle_t    mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: hdl/upd_back.sv
module upd_back import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  bundle_t    head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       byte_valid,
	output logic [7:0] decoded_byte,
	output logic       item_done,
	output logic       buffer_done,
	output logic [1:0] leftover_bytes
);

	logic [1:0] idx_q;
	logic       final_res;
	logic       xfer;

	assign out_valid = head_valid;
	assign xfer      = out_valid && out_ready;
	assign final_res = (idx_q == (head.cnt - 2'd1));
	assign pop       = xfer && final_res;

	// result fields for the current slot of the head bundle
	always_comb begin
		case (idx_q)
			2'd0:    decoded_byte = head.bytes[0];
			2'd1:    decoded_byte = head.bytes[1];
			2'd2:    decoded_byte = head.bytes[2];
			default: decoded_byte = 8'h00;
		endcase
	end

	assign byte_valid     = !head.pad;
	assign item_done      = final_res;
	assign buffer_done    = final_res && head.last;
	assign leftover_bytes = buffer_done ? head.left : 2'd0;

	// slot counter within the head bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (xfer) begin
			idx_q <= final_res ? 2'd0 : (idx_q + 2'd1);
		end
	end

endmodule

FILE: hdl/url_percent_decoder_top.sv
// Streaming urlencoded-text decoder: one byte is taken per transfer on the
// input channel, '+' becomes a space and '%' with two hex digits becomes one
// byte; a failed escape gives a literal '%' and replays the two bytes after it.
// The front end accepts one byte every cycle while the two-entry result queue
// has room, and the back end delivers one result per cycle while out_ready is
// high; a byte causes 0 to 3 results, and the sustained rate is one byte per
// cycle while no byte causes more than one result and out_ready stays high.
// A byte marked last_byte always yields at least one result, the final one
// carrying buffer_done and the count of unconsumed trailing escape bytes.
`include "url_percent_decoder_top_defines.svh"

module url_percent_decoder_top import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       byte_valid,
	output logic [7:0] decoded_byte,
	output logic       item_done,
	output logic       buffer_done,
	output logic [1:0] leftover_bytes
);

	logic    q_full;
	logic    push;
	bundle_t push_data;
	logic    pop;
	logic    head_valid;
	bundle_t head;

	// classify input bytes
	upd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	// decouple front from back
	upd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	// serialize results
	upd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.byte_valid     (byte_valid),
		.decoded_byte   (decoded_byte),
		.item_done      (item_done),
		.buffer_done    (buffer_done),
		.leftover_bytes (leftover_bytes)
	);

	// checks
	`UPD_ASSERT_IMP(a_bufdone_item, out_valid && buffer_done, item_done)
	`UPD_ASSERT_IMP(a_left_bufdone, out_valid && (leftover_bytes != 2'd0), buffer_done)
	`UPD_ASSERT_IMP(a_pad_bufdone, out_valid && !byte_valid, buffer_done)
	`UPD_ASSERT_NXT(a_full_room, push && q_full, 1'b0)

endmodule

FILE: dv/url_percent_decoder_top_tb.sv
module url_percent_decoder_top_tb;
	import upd_pkg::*;

	// one result transfer as seen on the output channel
	typedef struct {
		logic       byte_valid;
		logic [7:0] decoded_byte;
		logic       item_done;
		logic       buffer_done;
		logic [1:0] leftover_bytes;
	} decode_result_t;

	// tracks escape state and the queue of results still owed by the block
	class decode_scoreboard;
		logic [1:0]     phase;
		logic [7:0]     held;
		decode_result_t expected[$];
		decode_result_t fresh[$];
		int             mismatches;
		int             results_seen;
		int             escapes_decoded;
		int             escapes_replayed;

		function new();
			phase = PH_IDLE;
			held = 8'h00;
			mismatches = 0;
			results_seen = 0;
			escapes_decoded = 0;
			escapes_replayed = 0;
		endfunction

		function int outstanding();
			return expected.size();
		endfunction

		// {is digit, value} for an ascii hex digit of either case
		function logic [4:0] hex_digit(input logic [7:0] c);
			if (c >= 8'h30 && c <= 8'h39)
				return {1'b1, c[3:0]};
			else if (c >= 8'h61 && c <= 8'h66)
				return {1'b1, 4'(c - 8'h57)};
			else if (c >= 8'h41 && c <= 8'h46)
				return {1'b1, 4'(c - 8'h37)};
			return 5'd0;
		endfunction

		function void push_char(input logic [7:0] c);
			decode_result_t r;
			r.byte_valid = 1'b1;
			r.decoded_byte = c;
			r.item_done = 1'b0;
			r.buffer_done = 1'b0;
			r.leftover_bytes = 2'd0;
			fresh.push_back(r);
		endfunction

		// byte handling outside the second escape digit
		function void take_plain(input logic [7:0] c);
			if (phase == PH_IDLE) begin
				if (c == CHAR_PCT)
					phase = PH_PCT;
				else
					push_char(c == CHAR_PLUS ? CHAR_SPACE : c);
			end else begin
				held = c;
				phase = PH_HIGH;
			end
		endfunction

		// predict every result caused by one accepted input transfer
		function void note_byte(input logic [7:0] c, input logic closes);
			logic [4:0] hi_d;
			logic [4:0] lo_d;
			logic [1:0] left;
			fresh.delete();
			if (phase == PH_IDLE || phase == PH_PCT) begin
				take_plain(c);
			end else begin
				hi_d = hex_digit(held);
				lo_d = hex_digit(c);
				phase = PH_IDLE;
				if (hi_d[4] && lo_d[4]) begin
					push_char({hi_d[3:0], lo_d[3:0]});
					escapes_decoded++;
				end else begin
					// literal percent, then the held byte and this one go round again
					push_char(CHAR_PCT);
					take_plain(held);
					take_plain(c);
					escapes_replayed++;
				end
			end
			// buffer end drops any pending escape and reports its length
			if (closes) begin
				left = phase;
				if (fresh.size() == 0) begin
					push_char(8'h00);
					fresh[0].byte_valid = 1'b0;
				end
				fresh[$].buffer_done = 1'b1;
				fresh[$].leftover_bytes = left;
				phase = PH_IDLE;
			end
			if (fresh.size() > 0)
				fresh[$].item_done = 1'b1;
			foreach (fresh[i])
				expected.push_back(fresh[i]);
		endfunction

		// compare one output transfer with the oldest expectation
		function void check_result(input decode_result_t got);
			decode_result_t want;
			results_seen++;
			if (expected.size() == 0) begin
				$error("result with nothing expected: decoded_byte %02h", got.decoded_byte);
				mismatches++;
				return;
			end
			want = expected.pop_front();
			if (got.byte_valid !== want.byte_valid) begin
				$error("byte_valid: expected %0d, got %0d", want.byte_valid, got.byte_valid);
				mismatches++;
			end
			if (got.decoded_byte !== want.decoded_byte) begin
				$error("decoded_byte: expected %02h, got %02h", want.decoded_byte,
					got.decoded_byte);
				mismatches++;
			end
			if (got.item_done !== want.item_done) begin
				$error("item_done: expected %0d, got %0d", want.item_done, got.item_done);
				mismatches++;
			end
			if (got.buffer_done !== want.buffer_done) begin
				$error("buffer_done: expected %0d, got %0d", want.buffer_done,
					got.buffer_done);
				mismatches++;
			end
			if (got.leftover_bytes !== want.leftover_bytes) begin
				$error("leftover_bytes: expected %0d, got %0d", want.leftover_bytes,
					got.leftover_bytes);
				mismatches++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       last_byte;
	logic       out_valid;
	logic       out_ready;
	logic       byte_valid;
	logic [7:0] decoded_byte;
	logic       item_done;
	logic       buffer_done;
	logic [1:0] leftover_bytes;

	decode_scoreboard sb = new();
	bit               quiet;
	int               bytes_sent;
	int               buffers_sent;

	url_percent_decoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.byte_valid(byte_valid),
		.decoded_byte(decoded_byte),
		.item_done(item_done),
		.buffer_done(buffer_done),
		.leftover_bytes(leftover_bytes)
	);

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// receiver stalls at random except during the quiet stretch
	always @(negedge clk) begin
		out_ready <= quiet || ($urandom_range(99) >= 34);
	end

	// output monitor
	always @(posedge clk) begin : result_monitor
		decode_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.byte_valid = byte_valid;
			got.decoded_byte = decoded_byte;
			got.item_done = item_done;
			got.buffer_done = buffer_done;
			got.leftover_bytes = leftover_bytes;
			sb.check_result(got);
		end
	end

	// one input transfer; entered and left just after a rising edge
	task automatic send_byte(input logic [7:0] b, input logic closes);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		last_byte <= closes;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_byte(b, closes);
		bytes_sent++;
		if (closes)
			buffers_sent++;
	endtask

	task automatic send_text(input string s, input bit closes);
		int i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i], closes && (i == s.len() - 1));
	endtask

	// hold the sender off until the block owes nothing
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	function automatic logic [7:0] rand_hex();
		int v;
		v = $urandom_range(15);
		if (v < 10)
			return 8'h30 + 8'(v);
		return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(v - 10);
	endfunction

	// stimulus
	initial begin : stimulus
		logic [7:0] text[$];
		int         n_tokens;
		int         kind;
		int         t;
		int         i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		last_byte = 1'b0;
		out_ready = 1'b0;
		quiet = 1'b0;
		bytes_sent = 0;
		buffers_sent = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte extremes, plus to space, good escapes in both cases
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text("+%4f%aF", 1'b1);
		// failed escape whose replay holds a plus and a new escape
		send_text("%+%41", 1'b1);
		// bad second digit at buffer end
		send_text("%4g", 1'b1);
		// lone percent and percent plus one byte at buffer end
		send_text("%", 1'b1);
		send_text("%2", 1'b1);
		// percent held as the first digit, then replayed
		send_text("%%xz", 1'b1);
		wait_drained();

		// random buffers, mostly well-formed escapes with noise mixed in
		while (bytes_sent < 215) begin
			quiet = (bytes_sent >= 110 && bytes_sent < 160);
			text.delete();
			n_tokens = $urandom_range(1, 6);
			for (t = 0; t < n_tokens; t++) begin
				kind = $urandom_range(99);
				if (kind < 40) begin
					text.push_back(CHAR_PCT);
					text.push_back(rand_hex());
					text.push_back(rand_hex());
				end else if (kind < 55) begin
					text.push_back(8'($urandom_range(255)));
				end else if (kind < 65) begin
					text.push_back(CHAR_PLUS);
				end else if (kind < 80) begin
					text.push_back(CHAR_PCT);
					text.push_back($urandom_range(1) ? rand_hex() : 8'($urandom_range(255)));
					text.push_back($urandom_range(1) ? 8'($urandom_range(255)) : CHAR_PLUS);
				end else if (kind < 90) begin
					text.push_back(CHAR_PCT);
				end else begin
					text.push_back(rand_hex());
				end
			end
			// sometimes drop the last byte of the buffer, which may cut an escape
			if (text.size() > 1 && $urandom_range(4) == 0)
				void'(text.pop_back());
			for (i = 0; i < text.size(); i++)
				send_byte(text[i], i == text.size() - 1);
			if ($urandom_range(7) == 0)
				wait_drained();
		end
		quiet = 1'b0;

		wait_drained();
		repeat (16) @(posedge clk);
		$display("sent %0d bytes in %0d buffers; checked %0d results", bytes_sent,
			buffers_sent, sb.results_seen);
		$display("escapes decoded %0d, failed escapes replayed %0d", sb.escapes_decoded,
			sb.escapes_replayed);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#1000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/upd_pkg.sv
hdl/upd_front.sv
hdl/upd_queue.sv
hdl/upd_back.sv
hdl/url_percent_decoder_top.sv
dv/url_percent_decoder_top_tb.sv
